### hw/rtl/pcsht_pkg.sv
// Package for the sampled program counter hit table.
// Holds the table geometry, the controller/datapath structs and the hot test.
// Depends on nothing.
`default_nettype none

package pcsht_pkg;

   localparam int TableDepth  = 64;
   localparam int IdxWidth    = $clog2(TableDepth);
   localparam int CntWidth    = $clog2(TableDepth + 1);
   localparam logic [31:0] LimitReset = 32'd100000;

   localparam logic KindSample = 1'b0;
   localparam logic KindReport = 1'b1;
   localparam logic OpSample   = 1'b0;
   localparam logic OpReport   = 1'b1;

   typedef struct packed {
      logic sample_go;
      logic scan_start;
      logic scan_step;
      logic hot_clear;
      logic hot_acc;
      logic sel_acc;
      logic sel_first;
      logic emit_drop;
      logic emit_hit;
      logic emit_new;
      logic emit_full;
      logic emit_empty;
      logic emit_report;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic empty;
      logic full;
      logic scan_done;
      logic match;
      logic last_emit;
   } sts_type;

   // hits * 100 > samples, with the product built from shifts.
   function automatic logic is_hot(input logic [31:0] hits, input logic [31:0] samples);
      logic [38:0] prod;
      prod = {1'b0, hits, 6'b0} + {2'b0, hits, 5'b0} + {5'b0, hits, 2'b0};
      return prod > {7'b0, samples};
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pcsht_ctrl.sv
// Controller state machine for the hit table.
// Depends on pcsht_pkg for the command and status structs.
`default_nettype none

module pcsht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_opcode,
   input  wire pcsht_pkg::sts_type sts,
   output pcsht_pkg::cmd_type     cmd,
   output logic                   busy
);
   import pcsht_pkg::*;

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StSScan = 2'd1;
   localparam logic [1:0] StRHot  = 2'd2;
   localparam logic [1:0] StRSel  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign busy = (state_ff != StIdle);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (start) begin
               if (req_opcode == OpSample) begin
                  if (sts.drop) begin
                     cmd.emit_drop = 1'b1;
                  end else begin
                     cmd.sample_go  = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = StSScan;
                  end
               end else begin
                  if (sts.empty) begin
                     cmd.emit_empty = 1'b1;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.hot_clear  = 1'b1;
                     state_in       = StRHot;
                  end
               end
            end
         end
         StSScan: begin
            if (sts.match) begin
               cmd.emit_hit = 1'b1;
               state_in     = StIdle;
            end else if (sts.scan_done) begin
               if (sts.full) begin
                  cmd.emit_full = 1'b1;
               end else begin
                  cmd.emit_new = 1'b1;
               end
               state_in = StIdle;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         StRHot: begin
            cmd.hot_acc = 1'b1;
            if (sts.scan_done) begin
               cmd.scan_start = 1'b1;
               cmd.sel_first  = 1'b1;
               state_in       = StRSel;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         StRSel: begin
            cmd.sel_acc = 1'b1;
            if (sts.scan_done) begin
               cmd.emit_report = 1'b1;
               if (sts.last_emit) begin
                  state_in = StIdle;
               end else begin
                  cmd.scan_start = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pcsht_dpath.sv
// Datapath for the hit table: entry memories, counters, scan pipe and result register.
// Depends on pcsht_pkg for geometry, structs and the hot test.
`default_nettype none

module pcsht_dpath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data,
   input  wire logic [63:0]        req_pc,
   input  wire pcsht_pkg::cmd_type cmd,
   output pcsht_pkg::sts_type      sts,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic                    rsp_dropped,
   output logic                    rsp_entry_valid,
   output logic [5:0]              rsp_entry_index,
   output logic                    rsp_is_new,
   output logic                    rsp_table_full,
   output logic [63:0]             rsp_address,
   output logic [31:0]             rsp_hits,
   output logic                    rsp_hot,
   output logic [6:0]              rsp_hot_total,
   output logic [31:0]             rsp_sample_total,
   output logic                    rsp_last
);
   import pcsht_pkg::*;

   logic [63:0] mem_addr [TableDepth];
   logic [31:0] mem_hits [TableDepth];

   logic [31:0]         limit_ff, counter_ff;
   logic [CntWidth-1:0] count_ff, idx_ff, hot_cnt_ff, emit_cnt_ff;
   logic [63:0]         pc_ff, addr_q;
   logic [31:0]         hits_q;
   logic                pv_ff;
   logic [IdxWidth-1:0] pslot_ff;
   logic                best_found_ff, prev_first_ff;
   logic [31:0]         best_h_ff, prev_h_ff;
   logic [IdxWidth-1:0] best_s_ff, prev_s_ff;
   logic [63:0]         best_a_ff;
   logic [31:0]         hits_inc;
   logic                eligible, better;
   logic                hits_we;
   logic [IdxWidth-1:0] hits_wa;
   logic [31:0]         hits_wd;
   logic [CntWidth-1:0] emit_next;

   assign hits_inc  = (hits_q == '1) ? hits_q : hits_q + 32'd1;
   assign emit_next = emit_cnt_ff + CntWidth'(1);

   assign sts.drop      = (counter_ff >= limit_ff);
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CntWidth'(TableDepth));
   assign sts.scan_done = (idx_ff >= count_ff) && !pv_ff;
   assign sts.match     = pv_ff && (addr_q == pc_ff);
   assign sts.last_emit = (emit_next == count_ff);

   assign eligible = prev_first_ff || (hits_q < prev_h_ff) ||
                     ((hits_q == prev_h_ff) && (pslot_ff > prev_s_ff));
   assign better   = !best_found_ff || (hits_q > best_h_ff);

   assign hits_we = cmd.emit_hit || cmd.emit_new;
   assign hits_wa = cmd.emit_hit ? pslot_ff : count_ff[IdxWidth-1:0];
   assign hits_wd = cmd.emit_hit ? hits_inc : 32'd1;

   // Entry memories: one write port, registered read at the scan index.
   always_ff @(posedge clock) begin
      if (cmd.emit_new) begin
         mem_addr[count_ff[IdxWidth-1:0]] <= pc_ff;
      end
      if (hits_we) begin
         mem_hits[hits_wa] <= hits_wd;
      end
      addr_q <= mem_addr[idx_ff[IdxWidth-1:0]];
      hits_q <= mem_hits[idx_ff[IdxWidth-1:0]];
   end

   // Control state: limit, counters, scan pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LimitReset;
         counter_ff <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         pv_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.sample_go) begin
            counter_ff <= counter_ff + 32'd1;
         end
         if (cmd.emit_new) begin
            count_ff <= count_ff + CntWidth'(1);
         end
         if (cmd.scan_start) begin
            idx_ff <= '0;
            pv_ff  <= 1'b0;
         end else if (cmd.scan_step && (idx_ff < count_ff)) begin
            idx_ff <= idx_ff + CntWidth'(1);
            pv_ff  <= 1'b1;
         end else begin
            pv_ff <= 1'b0;
         end
      end
   end

   // Working registers for the scan passes.
   always_ff @(posedge clock) begin
      if (cmd.sample_go) begin
         pc_ff <= req_pc;
      end
      if (cmd.scan_step) begin
         pslot_ff <= idx_ff[IdxWidth-1:0];
      end
      if (cmd.hot_clear) begin
         hot_cnt_ff <= '0;
      end else if (cmd.hot_acc && pv_ff && is_hot(hits_q, counter_ff)) begin
         hot_cnt_ff <= hot_cnt_ff + CntWidth'(1);
      end
      if (cmd.scan_start) begin
         best_found_ff <= 1'b0;
      end else if (cmd.sel_acc && pv_ff && eligible && better) begin
         best_found_ff <= 1'b1;
         best_h_ff     <= hits_q;
         best_s_ff     <= pslot_ff;
         best_a_ff     <= addr_q;
      end
      if (cmd.sel_first) begin
         prev_first_ff <= 1'b1;
         emit_cnt_ff   <= '0;
      end else if (cmd.emit_report) begin
         prev_first_ff <= 1'b0;
         prev_h_ff     <= best_h_ff;
         prev_s_ff     <= best_s_ff;
         emit_cnt_ff   <= emit_next;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_drop || cmd.emit_hit || cmd.emit_new || cmd.emit_full ||
                      cmd.emit_empty || cmd.emit_report;
      end
      rsp_kind         <= (cmd.emit_empty || cmd.emit_report) ? KindReport : KindSample;
      rsp_dropped      <= cmd.emit_drop;
      rsp_entry_valid  <= cmd.emit_hit || cmd.emit_new || cmd.emit_report;
      rsp_is_new       <= cmd.emit_new;
      rsp_table_full   <= cmd.emit_full;
      rsp_sample_total <= counter_ff;
      rsp_last         <= !cmd.emit_report || sts.last_emit;
      rsp_entry_index  <= '0;
      rsp_address      <= '0;
      rsp_hits         <= '0;
      rsp_hot          <= 1'b0;
      rsp_hot_total    <= '0;
      if (cmd.emit_hit) begin
         rsp_entry_index <= 6'(pslot_ff);
         rsp_address     <= pc_ff;
         rsp_hits        <= hits_inc;
         rsp_hot         <= is_hot(hits_inc, counter_ff);
      end else if (cmd.emit_new) begin
         rsp_entry_index <= 6'(count_ff[IdxWidth-1:0]);
         rsp_address     <= pc_ff;
         rsp_hits        <= 32'd1;
         rsp_hot         <= is_hot(32'd1, counter_ff);
      end else if (cmd.emit_report) begin
         rsp_entry_index <= 6'(best_s_ff);
         rsp_address     <= best_a_ff;
         rsp_hits        <= best_h_ff;
         rsp_hot         <= is_hot(best_h_ff, counter_ff);
         rsp_hot_total   <= 7'(hot_cnt_ff);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pc_sample_hit_table.sv
// Top level of the sampled program counter hit table.
// Depends on pcsht_pkg, pcsht_ctrl and pcsht_dpath.
//
//   Channel    Ports                       Handshake
//   request    start, busy, req_*          taken when start is high and busy is low
//   response   rsp_valid, rsp_*            one cycle per result, no back-pressure
//   register   csr_wr_en, csr_wr_data      written on any edge with csr_wr_en high
//
// A sample transaction scans the table one entry per cycle through a registered
// memory read; a dropped sample answers without a scan. A report transaction
// takes one pass to count hot entries and then one pass per reported entry,
// since the entry memory has a single read port. Each result appears in the
// cycle after the decision that makes it. Reset is synchronous and needs no
// clearing pass, since only occupied slots are ever read. The receiver cannot
// stall, so results are never held back.
`default_nettype none

module pc_sample_hit_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_pc,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic             rsp_dropped,
   output logic             rsp_entry_valid,
   output logic [5:0]       rsp_entry_index,
   output logic             rsp_is_new,
   output logic             rsp_table_full,
   output logic [63:0]      rsp_address,
   output logic [31:0]      rsp_hits,
   output logic             rsp_hot,
   output logic [6:0]       rsp_hot_total,
   output logic [31:0]      rsp_sample_total,
   output logic             rsp_last
);
   import pcsht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences scans and decides which result to emit.
   pcsht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // The datapath holds the table, counters and the response register.
   pcsht_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_pc           (req_pc),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_dropped      (rsp_dropped),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .rsp_address      (rsp_address),
      .rsp_hits         (rsp_hits),
      .rsp_hot          (rsp_hot),
      .rsp_hot_total    (rsp_hot_total),
      .rsp_sample_total (rsp_sample_total),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

### hw/rtl/pcsht_checker.sv
// Port-level checker for the hit table, bound to the top level.
// Depends on the ports of pc_sample_hit_table only.
`default_nettype none

module pcsht_assertions (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_kind,
   input wire logic        rsp_dropped,
   input wire logic        rsp_entry_valid,
   input wire logic        rsp_is_new,
   input wire logic [31:0] rsp_hits,
   input wire logic [31:0] rsp_sample_total,
   input wire logic        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

   a_sample_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> rsp_last)
      else $error("sample transaction gave more than one result");

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (!rsp_entry_valid && !rsp_kind))
      else $error("dropped sample carries an entry");

   a_new_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_new) |-> (rsp_hits == 32'd1 && rsp_sample_total != 32'd0))
      else $error("new entry has wrong count");

endmodule

bind pc_sample_hit_table pcsht_assertions u_pcsht_assertions (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_kind         (rsp_kind),
   .rsp_dropped      (rsp_dropped),
   .rsp_entry_valid  (rsp_entry_valid),
   .rsp_is_new       (rsp_is_new),
   .rsp_hits         (rsp_hits),
   .rsp_sample_total (rsp_sample_total),
   .rsp_last         (rsp_last)
);

`default_nettype wire
